>>> rtl/sesae_pkg.sv
// Shared types, codes and widths for the stack engine with search and edit.
`timescale 1ns / 1ps
`default_nettype none

package sesae_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 3'd0,
        FUNC_POP     = 3'd1,
        FUNC_REVERSE = 3'd2,
        FUNC_SEARCH  = 3'd3,
        FUNC_ORDER   = 3'd4,
        FUNC_REMOVE  = 3'd5,
        FUNC_INSERT  = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_BAD_POS = 2'd3
    } status_t;

    typedef struct packed {
        logic shift_en;
        logic wr_en;
    } step_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/sesae_cell.sv
// One stack cell: holds one word, loads from its right neighbor or the write bus.
`timescale 1ns / 1ps
`default_nettype none

module sesae_cell
    import sesae_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic                aclk,
    input  wire step_ctrl_t          step,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire logic [DATA_W-1:0]   wr_data,
    input  wire logic [DATA_W-1:0]   right_data,
    output logic      [DATA_W-1:0]   cell_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] data_reg;
    logic              hit;
    logic              below;

    assign hit       = (wr_idx == MY_IDX);
    assign below     = (MY_IDX < wr_idx);
    assign cell_data = data_reg;

    always_ff @(posedge aclk) begin
        if (step.wr_en && hit) begin
            data_reg <= wr_data;
        end else if (step.shift_en && below) begin
            data_reg <= right_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sesae_ctrl.sv
// Sequencer: steps the cell row through each operation and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module sesae_ctrl
    import sesae_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int IDX_W = $clog2(STACK_DEPTH),
    localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [DATA_W-1:0]    s_value,
    input  wire logic [POS_W-1:0]     s_pos,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output status_t                   m_status,
    output logic                      m_flag,
    output logic [DATA_W-1:0]         m_popped,
    output logic [COUNT_W-1:0]        m_count,
    input  wire logic [DATA_W-1:0]    head_data,
    output step_ctrl_t                step,
    output logic [IDX_W-1:0]          wr_idx,
    output logic [DATA_W-1:0]         wr_data
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    func_t                op_reg, op_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 ins_done_reg, ins_done_next;
    logic [DATA_W-1:0]    prev_reg, prev_next;
    logic                 flag_reg, flag_next;
    logic [DATA_W-1:0]    popped_reg, popped_next;
    status_t              status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    status_t              m_status_reg, m_status_next;
    logic                 m_flag_reg, m_flag_next;
    logic [DATA_W-1:0]    m_popped_reg, m_popped_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;

    logic                 last_k;
    logic [CMP_W-1:0]     in_pos_ext;
    logic [CMP_W-1:0]     len_ext;
    logic                 at_ins_pos;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_flag   = m_flag_reg;
    assign m_popped = m_popped_reg;
    assign m_count  = m_count_reg;

    assign last_k     = (k_reg == n_reg - ONE_CNT);
    assign in_pos_ext = CMP_W'(s_pos);
    assign len_ext    = CMP_W'(len_reg);
    assign at_ins_pos = (CMP_W'(pos_reg) == CMP_W'(k_reg) + CMP_W'(1));

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        ins_done_next = ins_done_reg;
        prev_next     = prev_reg;
        flag_next     = flag_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        m_flag_next   = m_flag_reg;
        m_popped_next = m_popped_reg;
        m_count_next  = m_count_reg;
        step          = '0;
        wr_idx        = '0;
        wr_data       = head_data;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = func_t'(s_func);
                    val_next      = s_value;
                    pos_next      = s_pos;
                    k_next        = '0;
                    n_next        = len_reg;
                    ins_done_next = 1'b0;
                    flag_next     = (func_t'(s_func) == FUNC_ORDER);
                    popped_next   = '0;
                    status_next   = STATUS_OK;
                    state_next    = ST_RUN;
                    case (func_t'(s_func))
                        FUNC_PUSH: begin
                            if (len_reg == FULL_CNT) begin
                                status_next = STATUS_FULL;
                                state_next  = ST_FIN;
                            end
                        end
                        FUNC_POP: begin
                            if (len_reg == '0) begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_FIN;
                            end
                        end
                        FUNC_REVERSE: begin
                            if (len_reg < TWO_CNT) begin
                                state_next = ST_FIN;
                            end
                        end
                        FUNC_SEARCH, FUNC_ORDER, FUNC_REMOVE: begin
                            if (len_reg == '0) begin
                                state_next = ST_FIN;
                            end
                        end
                        FUNC_INSERT: begin
                            if (len_reg == FULL_CNT) begin
                                status_next = STATUS_FULL;
                                state_next  = ST_FIN;
                            end else if (in_pos_ext == '0 || in_pos_ext > len_ext) begin
                                status_next = STATUS_BAD_POS;
                                state_next  = ST_FIN;
                            end
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                case (op_reg)
                    FUNC_PUSH: begin
                        step.wr_en = 1'b1;
                        wr_idx     = IDX_W'(len_reg);
                        wr_data    = val_reg;
                        len_next   = len_reg + ONE_CNT;
                        state_next = ST_FIN;
                    end
                    FUNC_POP: begin
                        step.shift_en = 1'b1;
                        wr_idx        = IDX_W'(len_reg - ONE_CNT);
                        k_next        = k_reg + ONE_CNT;
                        if (last_k) begin
                            popped_next = head_data;
                            len_next    = len_reg - ONE_CNT;
                            state_next  = ST_FIN;
                        end else begin
                            step.wr_en = 1'b1;
                        end
                    end
                    FUNC_REVERSE: begin
                        step.shift_en = 1'b1;
                        step.wr_en    = 1'b1;
                        wr_idx        = IDX_W'(n_reg - ONE_CNT - k_reg);
                        k_next        = k_reg + ONE_CNT;
                        if (k_reg == n_reg - TWO_CNT) begin
                            state_next = ST_FIN;
                        end
                    end
                    FUNC_SEARCH: begin
                        step.shift_en = 1'b1;
                        step.wr_en    = 1'b1;
                        wr_idx        = IDX_W'(len_reg - ONE_CNT);
                        k_next        = k_reg + ONE_CNT;
                        if (head_data == val_reg) begin
                            flag_next = 1'b1;
                        end
                        if (last_k) begin
                            state_next = ST_FIN;
                        end
                    end
                    FUNC_ORDER: begin
                        step.shift_en = 1'b1;
                        step.wr_en    = 1'b1;
                        wr_idx        = IDX_W'(len_reg - ONE_CNT);
                        k_next        = k_reg + ONE_CNT;
                        prev_next     = head_data;
                        if (k_reg != '0 && $signed(head_data) < $signed(prev_reg)) begin
                            flag_next = 1'b0;
                        end
                        if (last_k) begin
                            state_next = ST_FIN;
                        end
                    end
                    FUNC_REMOVE: begin
                        step.shift_en = 1'b1;
                        wr_idx        = IDX_W'(len_reg - ONE_CNT);
                        k_next        = k_reg + ONE_CNT;
                        if (head_data == val_reg) begin
                            flag_next = 1'b1;
                            len_next  = len_reg - ONE_CNT;
                        end else begin
                            step.wr_en = 1'b1;
                        end
                        if (last_k) begin
                            state_next = ST_FIN;
                        end
                    end
                    FUNC_INSERT: begin
                        if (!ins_done_reg && at_ins_pos) begin
                            step.wr_en    = 1'b1;
                            wr_idx        = IDX_W'(len_reg);
                            wr_data       = val_reg;
                            len_next      = len_reg + ONE_CNT;
                            ins_done_next = 1'b1;
                        end else begin
                            step.shift_en = 1'b1;
                            step.wr_en    = 1'b1;
                            wr_idx        = IDX_W'(len_reg - ONE_CNT);
                            k_next        = k_reg + ONE_CNT;
                            if (last_k) begin
                                state_next = ST_FIN;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_flag_next   = flag_reg && (status_reg == STATUS_OK);
                    m_popped_next = popped_reg;
                    m_count_next  = COUNT_W'(len_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        ins_done_reg <= ins_done_next;
        prev_reg     <= prev_next;
        flag_reg     <= flag_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_flag_reg   <= m_flag_next;
        m_popped_reg <= m_popped_next;
        m_count_reg  <= m_count_next;
    end

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted but sequencer did not leave idle");

    a_err_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg) && m_status_reg != STATUS_OK)
            |-> (m_count_reg == COUNT_W'(n_reg)))
        else $error("rejected request changed the entry count");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg) && m_status_reg != STATUS_OK)
            |-> (!m_flag_reg && m_popped_reg == '0))
        else $error("rejected request carries flag or popped data");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FULL_CNT)
        else $error("entry count beyond stack depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step.wr_en) |-> (CNT_W'(wr_idx) <= len_reg))
        else $error("cell write beyond current stack length");
`endif

endmodule

`default_nettype wire

>>> rtl/stack_engine_with_search_and_edit_core.sv
// Top level: stream ports, sequencer and the row of stack cells.
// Sequence: a request is accepted in idle; the run state then writes once for push,
// rotates the stored entries for pop, search, order check, remove and reverse, and
// rotates them with one extra write for insert; the finish state loads the result word.
// Throughput: one word at a time, set by the cell row rotating past cell 0.
// Reset: aresetn clears the entry count and the handshake; cell contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module stack_engine_with_search_and_edit_core
    import sesae_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // operand_value[31:0], insert_position[36:32]
    input  wire logic [FUNC_W-1:0]      s_tuser,   // func[2:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // flag[0], popped_value[32:1], entry_count[37:33]
    output logic [STATUS_W-1:0]         m_tuser    // status[1:0]
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    step_ctrl_t          step;
    logic [IDX_W-1:0]    wr_idx;
    logic [DATA_W-1:0]   wr_data;
    logic [DATA_W-1:0]   cell_q [STACK_DEPTH];
    status_t             res_status;
    logic                res_flag;
    logic [DATA_W-1:0]   res_popped;
    logic [COUNT_W-1:0]  res_count;

    sesae_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser),
        .s_value   (s_tdata[DATA_W-1:0]),
        .s_pos     (s_tdata[DATA_W+POS_W-1:DATA_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_status  (res_status),
        .m_flag    (res_flag),
        .m_popped  (res_popped),
        .m_count   (res_count),
        .head_data (cell_q[0]),
        .step      (step),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data)
    );

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] right_data;
        if (g == STACK_DEPTH - 1) begin : g_end
            assign right_data = cell_q[g];
        end else begin : g_mid
            assign right_data = cell_q[g+1];
        end
        sesae_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .step       (step),
            .wr_idx     (wr_idx),
            .wr_data    (wr_data),
            .right_data (right_data),
            .cell_data  (cell_q[g])
        );
    end

    assign m_tdata = {{(M_TDATA_W - 1 - DATA_W - COUNT_W){1'b0}}, res_count, res_popped, res_flag};
    assign m_tuser = res_status;

endmodule

`default_nettype wire

>>> tb/tb_stack_engine_with_search_and_edit_core.sv
// Self-checking stream testbench for the stack engine with search and edit.
`timescale 1ns / 1ps

module tb_stack_engine_with_search_and_edit_core;
    import sesae_pkg::*;

    localparam int              DEPTH          = DEFAULT_STACK_DEPTH;
    localparam int              RANDOM_WORDS   = 1900;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              LONG_HOLD      = 400;
    localparam int              HOLD_AFTER     = 500;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0] code;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
        bit                drain;
    } request_t;

    typedef struct {
        status_t             status;
        logic                flag;
        logic [DATA_W-1:0]   popped;
        logic [COUNT_W-1:0]  count;
    } result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // operand_value[31:0], insert_position[36:32]
    logic [FUNC_W-1:0]     s_tuser;   // func[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // flag[0], popped_value[32:1], entry_count[37:33]
    logic [STATUS_W-1:0]   m_tuser;   // status[1:0]

    request_t  pending_words[$];
    result_t   expected_results[$];

    logic signed [DATA_W-1:0] stack_model [0:DEPTH-1];
    int        stack_fill;
    int        peak_fill;

    int        errors;
    int        words_in;
    int        words_out;
    int        func_seen [0:7];
    int        status_seen [0:3];
    int        ordered_true;
    int        found_true;
    bit        in_fired;
    int        burst_left;
    int        gap_left;
    int        rx_mode;
    int        rx_left;
    int        rx_tick;
    int        hold_left;
    bit        hold_done;
    int        stall_cycles;
    result_t   want;
    result_t   got;

    stack_engine_with_search_and_edit_core #(
        .STACK_DEPTH (DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_t predict_result(logic [FUNC_W-1:0] code,
                                               logic [DATA_W-1:0] val,
                                               logic [POS_W-1:0] pos);
        result_t                  r;
        int                       i;
        int                       j;
        logic signed [DATA_W-1:0] t;
        r.status = STATUS_OK;
        r.flag   = 1'b0;
        r.popped = '0;
        case (code)
            FUNC_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    stack_model[stack_fill] = val;
                    stack_fill++;
                end
            end
            FUNC_POP: begin
                if (stack_fill == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    stack_fill--;
                    r.popped = stack_model[stack_fill];
                end
            end
            FUNC_REVERSE: begin
                i = 0;
                j = stack_fill - 1;
                while (i < j) begin
                    t = stack_model[i];
                    stack_model[i] = stack_model[j];
                    stack_model[j] = t;
                    i++;
                    j--;
                end
            end
            FUNC_SEARCH: begin
                for (i = 0; i < stack_fill; i++)
                    if (stack_model[i] == val) r.flag = 1'b1;
            end
            FUNC_ORDER: begin
                r.flag = 1'b1;
                for (i = 1; i < stack_fill; i++)
                    if (stack_model[i] < stack_model[i-1]) r.flag = 1'b0;
            end
            FUNC_REMOVE: begin
                j = 0;
                for (i = 0; i < stack_fill; i++) begin
                    if (stack_model[i] == val) begin
                        r.flag = 1'b1;
                    end else begin
                        stack_model[j] = stack_model[i];
                        j++;
                    end
                end
                stack_fill = j;
            end
            FUNC_INSERT: begin
                if (stack_fill >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else if (pos < 1 || pos > stack_fill) begin
                    r.status = STATUS_BAD_POS;
                end else begin
                    for (i = stack_fill; i >= pos; i--)
                        stack_model[i] = stack_model[i-1];
                    stack_model[pos-1] = val;
                    stack_fill++;
                end
            end
            default: begin
            end
        endcase
        r.count = stack_fill[COUNT_W-1:0];
        if (stack_fill > peak_fill) peak_fill = stack_fill;
        return r;
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] code, logic [DATA_W-1:0] val,
                                 logic [POS_W-1:0] pos, bit drain);
        request_t q;
        q.code  = code;
        q.val   = val;
        q.pos   = pos;
        q.drain = drain;
        pending_words.push_back(q);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 4) return $urandom();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'h0000_0001;
            5: return 32'h0000_002A;
            6: return 32'hFFFF_FFD6;
            default: return 32'h5A5A_A5A5;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(1, DEPTH));
    endfunction

    task automatic queue_mixed(bit grow, bit drain);
        int               roll;
        logic [FUNC_W-1:0] code;
        roll = $urandom_range(0, 99);
        if (grow) begin
            if (roll < 35)      code = FUNC_PUSH;
            else if (roll < 55) code = FUNC_INSERT;
            else if (roll < 65) code = FUNC_POP;
            else if (roll < 75) code = FUNC_SEARCH;
            else if (roll < 80) code = FUNC_ORDER;
            else if (roll < 85) code = FUNC_REMOVE;
            else if (roll < 95) code = FUNC_REVERSE;
            else                code = FUNC_NOP;
        end else begin
            if (roll < 40)      code = FUNC_POP;
            else if (roll < 60) code = FUNC_REMOVE;
            else if (roll < 70) code = FUNC_SEARCH;
            else if (roll < 80) code = FUNC_ORDER;
            else if (roll < 90) code = FUNC_REVERSE;
            else                code = FUNC_PUSH;
        end
        queue_request(code, pick_value(), pick_position(), drain);
    endtask

    initial begin
        int                       seg;
        int                       n;
        int                       k;
        bit                       drain;
        logic signed [DATA_W-1:0] v;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        stack_fill   = 0;
        peak_fill    = 0;
        errors       = 0;
        words_in     = 0;
        words_out    = 0;
        ordered_true = 0;
        found_true   = 0;
        in_fired     = 1'b0;
        burst_left   = 1;
        gap_left     = 0;
        rx_mode      = 0;
        rx_left      = 0;
        rx_tick      = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        stall_cycles = 0;
        for (k = 0; k < 8; k++) func_seen[k] = 0;
        for (k = 0; k < 4; k++) status_seen[k] = 0;

        queue_request(FUNC_POP,     32'h0,          5'd0,  1'b0);
        queue_request(FUNC_ORDER,   32'h0,          5'd0,  1'b0);
        queue_request(FUNC_INSERT,  32'h1234_5678,  5'd1,  1'b0);
        queue_request(FUNC_REVERSE, 32'h0,          5'd0,  1'b0);
        queue_request(FUNC_SEARCH,  32'h5,          5'd0,  1'b0);
        queue_request(FUNC_REMOVE,  32'h5,          5'd0,  1'b0);
        queue_request(FUNC_NOP,     32'hFFFF_FFFF,  5'd31, 1'b0);
        queue_request(FUNC_PUSH,    32'h8000_0000,  5'd0,  1'b0);
        queue_request(FUNC_ORDER,   32'h0,          5'd0,  1'b0);
        queue_request(FUNC_PUSH,    32'h7FFF_FFFF,  5'd0,  1'b0);
        queue_request(FUNC_PUSH,    32'hFFFF_FFFF,  5'd0,  1'b0);
        queue_request(FUNC_PUSH,    32'h0,          5'd0,  1'b0);
        queue_request(FUNC_ORDER,   32'h0,          5'd0,  1'b0);
        queue_request(FUNC_SEARCH,  32'hFFFF_FFFF,  5'd0,  1'b0);
        queue_request(FUNC_SEARCH,  32'h0001_2345,  5'd0,  1'b0);
        queue_request(FUNC_INSERT,  32'h0000_0063,  5'd1,  1'b0);
        queue_request(FUNC_INSERT,  32'h0000_0055,  5'd5,  1'b0);
        queue_request(FUNC_INSERT,  32'h0000_0011,  5'd0,  1'b0);
        queue_request(FUNC_INSERT,  32'h0000_0022,  5'd7,  1'b0);
        queue_request(FUNC_INSERT,  32'h0000_0033,  5'd31, 1'b0);
        queue_request(FUNC_PUSH,    32'hFFFF_FFFF,  5'd0,  1'b0);
        queue_request(FUNC_REMOVE,  32'hFFFF_FFFF,  5'd0,  1'b0);
        queue_request(FUNC_REMOVE,  32'h0000_0309,  5'd0,  1'b0);
        queue_request(FUNC_REVERSE, 32'h0,          5'd0,  1'b0);
        queue_request(FUNC_POP,     32'h0,          5'd0,  1'b0);
        queue_request(FUNC_POP,     32'h0,          5'd0,  1'b0);

        n = 0;
        while (n < RANDOM_WORDS) begin
            seg   = $urandom_range(0, 9);
            drain = (n == 0) || ($urandom_range(0, 3) == 0);
            case (seg)
                0, 1, 2, 3: begin
                    for (k = $urandom_range(20, 40); k > 0; k--) begin
                        queue_mixed(1'b1, drain);
                        drain = 1'b0;
                        n++;
                    end
                end
                4, 5: begin
                    for (k = $urandom_range(10, 30); k > 0; k--) begin
                        queue_mixed(1'b0, drain);
                        drain = 1'b0;
                        n++;
                    end
                end
                6, 7: begin
                    for (k = 0; k < DEPTH + 1; k++) begin
                        queue_request(FUNC_POP, $urandom(), POS_W'($urandom_range(0, 31)),
                                      drain);
                        drain = 1'b0;
                    end
                    v = $urandom_range(0, 1) ? $signed(pick_value()) : -$signed(32'd50);
                    for (k = $urandom_range(2, DEPTH); k > 0; k--) begin
                        queue_request(FUNC_PUSH, v, 5'd0, 1'b0);
                        if ($urandom_range(0, 3) == 0)
                            queue_request(FUNC_ORDER, $urandom(), 5'd0, 1'b0);
                        if (v < 32'sh7FFF_FFF0) v = v + $urandom_range(0, 3);
                        n++;
                    end
                    queue_request(FUNC_ORDER,   $urandom(), 5'd0, 1'b0);
                    queue_request(FUNC_REVERSE, $urandom(), 5'd0, 1'b0);
                    queue_request(FUNC_ORDER,   $urandom(), 5'd0, 1'b0);
                    n += DEPTH + 4;
                end
                8: begin
                    for (k = 0; k < DEPTH + 2; k++) begin
                        queue_request(FUNC_PUSH, pick_value(), 5'd0, drain);
                        drain = 1'b0;
                    end
                    queue_request(FUNC_INSERT,  pick_value(), pick_position(), 1'b0);
                    queue_request(FUNC_ORDER,   $urandom(),   5'd0, 1'b0);
                    queue_request(FUNC_REVERSE, $urandom(),   5'd0, 1'b0);
                    queue_request(FUNC_SEARCH,  pick_value(), 5'd0, 1'b0);
                    queue_request(FUNC_REMOVE,  pick_value(), 5'd0, 1'b0);
                    queue_request(FUNC_POP,     $urandom(),   5'd0, 1'b0);
                    n += DEPTH + 8;
                end
                default: begin
                    for (k = $urandom_range(5, 12); k > 0; k--) begin
                        queue_request(FUNC_W'($urandom_range(0, 7)), $urandom(),
                                      POS_W'($urandom_range(0, 31)), drain);
                        drain = 1'b0;
                        n++;
                    end
                end
            endcase
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (2 * (DEPTH + 3)) @(posedge aclk);

        $display("run: %0d requests, push %0d pop %0d reverse %0d search %0d order %0d",
                 words_in, func_seen[0], func_seen[1], func_seen[2], func_seen[3],
                 func_seen[4]);
        $write("run: remove %0d insert %0d nop %0d; ok %0d empty %0d full %0d bad-pos %0d",
               func_seen[5], func_seen[6], func_seen[7], status_seen[0], status_seen[1],
               status_seen[2], status_seen[3]);
        $display(", hits %0d, ordered %0d, peak %0d", found_true, ordered_true, peak_fill);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fired) begin
                in_fired = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end
                if (pending_words.size() == 0) s_tvalid <= 1'b0;
                else if (gap_left > 0 && hold_left == 0) s_tvalid <= 1'b0;
                else if (pending_words[0].drain) s_tvalid <= 1'b0;
                else begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_words[0].code;
                    s_tdata  <= {{(S_TDATA_W-DATA_W-POS_W){1'b0}},
                                 pending_words[0].pos, pending_words[0].val};
                end
            end else if (!s_tvalid) begin
                if (gap_left > 0 && hold_left == 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain && expected_results.size() != 0)) begin
                    gap_left = 0;
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_words[0].code;
                    s_tdata  <= {{(S_TDATA_W-DATA_W-POS_W){1'b0}},
                                 pending_words[0].pos, pending_words[0].val};
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && words_in >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                if (rx_left <= 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(10, 80);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_words.pop_front();
                expected_results.push_back(predict_result(s_tuser, s_tdata[DATA_W-1:0],
                                                          s_tdata[DATA_W+POS_W-1:DATA_W]));
                if (s_tuser == FUNC_ORDER && expected_results[$].flag) ordered_true++;
                func_seen[s_tuser]++;
                words_in++;
                in_fired = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                words_out++;
                got.status = status_t'(m_tuser);
                got.flag   = m_tdata[0];
                got.popped = m_tdata[32:1];
                got.count  = m_tdata[37:33];
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word status %0d flag %0d popped %h count %0d",
                             $time, got.status, got.flag, got.popped, got.count);
                end else begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (want.flag && s_tvalid !== 1'bx) begin
                        if (want.popped == '0 && want.status == STATUS_OK) found_true++;
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.flag !== want.flag) begin
                        errors++;
                        $display("%0t: flag expected %0d actual %0d",
                                 $time, want.flag, got.flag);
                    end
                    if (got.popped !== want.popped) begin
                        errors++;
                        $display("%0t: popped_value expected %h actual %h",
                                 $time, want.popped, got.popped);
                    end
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/sesae_pkg.sv
rtl/sesae_cell.sv
rtl/sesae_ctrl.sv
rtl/stack_engine_with_search_and_edit_core.sv
tb/tb_stack_engine_with_search_and_edit_core.sv
